[design/rplfv_pkg.sv]
// shared types, constants and constant functions of the face viscosity pipeline
`default_nettype none
package rplfv_pkg;

  localparam int DATA_W     = 32;
  localparam int FLOW_W     = 19;
  localparam int ADDR_W     = 5;
  localparam int N_FRAC     = 16;
  localparam int ABC_W      = 37;
  localparam int MAG_W      = 36;
  localparam int MS_W       = 30;
  localparam int SQ_W       = 60;
  localparam int SUM_W      = 63;
  localparam int ROOT_W     = 32;
  localparam int SQRT_STEPS = 32;
  localparam int K_W        = 3;
  localparam int T_W        = 41;
  localparam int STR_LAT    = 5 + SQRT_STEPS;

  localparam logic [T_W-1:0]    TERM_SAT = T_W'(64'd1 << 40);
  localparam logic [FLOW_W-1:0] FLOW_ONE = FLOW_W'(32'd1 << N_FRAC);

  typedef enum logic [2:0] {
    REG_YIELD = 3'd0,
    REG_BASE  = 3'd1,
    REG_FLOW  = 3'd2,
    REG_CAP   = 3'd3,
    REG_CELL  = 3'd4,
    REG_FACE  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] ux_here;
    logic signed [DATA_W-1:0] ux_left;
    logic signed [DATA_W-1:0] ux_up;
    logic signed [DATA_W-1:0] ux_down;
    logic signed [DATA_W-1:0] ux_left_up;
    logic signed [DATA_W-1:0] ux_left_down;
    logic signed [DATA_W-1:0] uy_here;
    logic signed [DATA_W-1:0] uy_left;
    logic signed [DATA_W-1:0] uy_up;
    logic signed [DATA_W-1:0] uy_down;
    logic signed [DATA_W-1:0] uy_left_up;
    logic signed [DATA_W-1:0] uy_left_down;
  } stencil_t;

  typedef struct packed {
    logic           zero;
    logic [K_W-1:0] k;
  } strain_flags_t;

  typedef struct packed {
    logic           zero;
    logic [T_W-1:0] t1;
  } pow_side_t;

  // bitwise integer square root, only evaluated at elaboration
  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_v;
    rem   = x;
    res   = '0;
    bit_v = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // q30 value of 2^(2^-i)
  function automatic logic [31:0] exp_root(int unsigned i);
    logic [63:0] r;
    r = 64'd2 << 30;
    for (int unsigned j = 1; j <= i; j++) begin
      r = isqrt64(r << 30);
    end
    return r[31:0];
  endfunction

endpackage
`default_nettype wire

[design/rplfv_if.sv]
// stream interfaces for stencil beats and result beats
`default_nettype none
interface rplfv_in_if;
  logic                 valid;
  logic                 ready;
  logic signed [31:0]   ux_here;
  logic signed [31:0]   ux_left;
  logic signed [31:0]   ux_up;
  logic signed [31:0]   ux_down;
  logic signed [31:0]   ux_left_up;
  logic signed [31:0]   ux_left_down;
  logic signed [31:0]   uy_here;
  logic signed [31:0]   uy_left;
  logic signed [31:0]   uy_up;
  logic signed [31:0]   uy_down;
  logic signed [31:0]   uy_left_up;
  logic signed [31:0]   uy_left_down;
  modport source (output valid, ux_here, ux_left, ux_up, ux_down, ux_left_up, ux_left_down,
                  uy_here, uy_left, uy_up, uy_down, uy_left_up, uy_left_down, input ready);
  modport sink (input valid, ux_here, ux_left, ux_up, ux_down, ux_left_up, ux_left_down,
                uy_here, uy_left, uy_up, uy_down, uy_left_up, uy_left_down, output ready);
endinterface

interface rplfv_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] face_viscosity;
  logic        at_cap;
  modport source (output valid, face_viscosity, at_cap, input ready);
  modport sink (input valid, face_viscosity, at_cap, output ready);
endinterface
`default_nettype wire

[design/rplfv_strain.sv]
// strain sums, range reduction, squared norm and pipelined integer square root
`default_nettype none
module rplfv_strain (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire rplfv_pkg::stencil_t     stencil_i,
  output logic [rplfv_pkg::ROOT_W-1:0] m_o,
  output rplfv_pkg::strain_flags_t     flags_o
);
  localparam int ABC_W = rplfv_pkg::ABC_W;
  localparam int MAG_W = rplfv_pkg::MAG_W;
  localparam int MS_W  = rplfv_pkg::MS_W;
  localparam int SQ_W  = rplfv_pkg::SQ_W;
  localparam int SUM_W = rplfv_pkg::SUM_W;
  localparam int RT_W  = rplfv_pkg::ROOT_W;
  localparam int N_ST  = rplfv_pkg::SQRT_STEPS;
  localparam int K_W   = rplfv_pkg::K_W;
  localparam int REM_W = RT_W + 2;
  localparam int CUR_W = REM_W + 2;
  localparam int X_W   = 2 * N_ST;

  logic signed [ABC_W-1:0] a_q, b_q, c_q;
  logic [MAG_W-1:0]        ma_q, mb_q, mc_q;
  logic [MS_W-1:0]         sa_q, sb_q, sc_q;
  logic [SQ_W-1:0]         pa_q, pb_q, pc_q;
  logic [SUM_W-1:0]        sum_q;
  rplfv_pkg::strain_flags_t fl3_q, fl4_q, fl5_q;

  logic signed [ABC_W-1:0] a_d, b_d, c_d;
  logic [MAG_W-1:0]        mx;
  logic [K_W-1:0]          k_d;
  logic [MAG_W-1:0]        sha, shb, shc;

  always_comb begin
    a_d = (ABC_W'(stencil_i.ux_here) - ABC_W'(stencil_i.ux_left)) <<< 2;
    b_d = (ABC_W'(stencil_i.uy_up) - ABC_W'(stencil_i.uy_down))
        + (ABC_W'(stencil_i.uy_left_up) - ABC_W'(stencil_i.uy_left_down));
    c_d = (ABC_W'(stencil_i.ux_up) - ABC_W'(stencil_i.ux_down))
        + (ABC_W'(stencil_i.ux_left_up) - ABC_W'(stencil_i.ux_left_down))
        + ((ABC_W'(stencil_i.uy_here) - ABC_W'(stencil_i.uy_left)) <<< 2);
  end

  // shift all three so the largest stays below 2^30
  always_comb begin
    mx = (ma_q > mb_q) ? ma_q : mb_q;
    if (mc_q > mx) mx = mc_q;
    k_d = '0;
    for (int j = MS_W; j < MAG_W; j++) begin
      if (mx[j]) k_d = K_W'(j - MS_W + 1);
    end
    sha = ma_q >> k_d;
    shb = mb_q >> k_d;
    shc = mc_q >> k_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= a_d;
      b_q   <= b_d;
      c_q   <= c_d;
      ma_q  <= MAG_W'(a_q[ABC_W-1] ? -a_q : a_q);
      mb_q  <= MAG_W'(b_q[ABC_W-1] ? -b_q : b_q);
      mc_q  <= MAG_W'(c_q[ABC_W-1] ? -c_q : c_q);
      sa_q  <= sha[MS_W-1:0];
      sb_q  <= shb[MS_W-1:0];
      sc_q  <= shc[MS_W-1:0];
      fl3_q <= '{zero: (mx == '0), k: k_d};
      pa_q  <= SQ_W'(sa_q) * SQ_W'(sa_q);
      pb_q  <= SQ_W'(sb_q) * SQ_W'(sb_q);
      pc_q  <= SQ_W'(sc_q) * SQ_W'(sc_q);
      fl4_q <= fl3_q;
      sum_q <= (SUM_W'(pa_q) << 1) + (SUM_W'(pb_q) << 1) + SUM_W'(pc_q);
      fl5_q <= fl4_q;
    end
  end

  // one root bit per stage
  logic [REM_W-1:0]         rem_q  [N_ST];
  logic [RT_W-1:0]          root_q [N_ST];
  logic [X_W-1:0]           x_q    [N_ST];
  rplfv_pkg::strain_flags_t fl_q   [N_ST];

  for (genvar s = 0; s < N_ST; s++) begin : g_sqrt
    logic [REM_W-1:0]         rem_in;
    logic [RT_W-1:0]          root_in;
    logic [X_W-1:0]           x_in;
    rplfv_pkg::strain_flags_t fl_in;
    logic [CUR_W-1:0]         cur, trial;
    logic                     ge;
    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = X_W'(sum_q);
      assign fl_in   = fl5_q;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign x_in    = x_q[s-1];
      assign fl_in   = fl_q[s-1];
    end
    assign cur   = {rem_in, x_in[X_W-1 -: 2]};
    assign trial = CUR_W'({root_in, 2'b01});
    assign ge    = (cur >= trial);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
        root_q[s] <= {root_in[RT_W-2:0], ge};
        x_q[s]    <= x_in << 2;
        fl_q[s]   <= fl_in;
      end
    end
  end

  assign m_o     = root_q[N_ST-1];
  assign flags_o = fl_q[N_ST-1];
endmodule
`default_nettype wire

[design/rplfv_div.sv]
// restoring divider, one quotient bit per pipeline stage, with side data
`default_nettype none
module rplfv_div #(
  parameter int N_W = 51,
  parameter int D_W = 32,
  parameter int S_W = 1
) (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [N_W-1:0] num_i,
  input  wire logic [D_W-1:0] den_i,
  input  wire logic [S_W-1:0] side_i,
  output logic [N_W-1:0]      quo_o,
  output logic [S_W-1:0]      side_o
);
  logic [D_W-1:0] rem_q  [N_W];
  logic [N_W-1:0] nq_q   [N_W];
  logic [D_W-1:0] den_q  [N_W];
  logic [S_W-1:0] side_q [N_W];

  for (genvar s = 0; s < N_W; s++) begin : g_stage
    logic [D_W-1:0] rem_in, den_in;
    logic [N_W-1:0] nq_in;
    logic [S_W-1:0] side_in;
    logic [D_W:0]   cur, diff;
    logic           ge;
    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign nq_in   = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign nq_in   = nq_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end
    // numerator bits shift out the top while quotient bits fill the bottom
    assign cur  = {rem_in, nq_in[N_W-1]};
    assign diff = cur - {1'b0, den_in};
    assign ge   = (cur >= {1'b0, den_in});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? diff[D_W-1:0] : cur[D_W-1:0];
        nq_q[s]   <= {nq_in[N_W-2:0], ge};
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign quo_o  = nq_q[N_W-1];
  assign side_o = side_q[N_W-1];
endmodule
`default_nettype wire

[design/rplfv_pow.sv]
// base_viscosity * g^(n-1) through a squaring log2 and a root-product exp2
`default_nettype none
module rplfv_pow #(
  parameter int G_W                = 51,
  parameter int FRAC_BITS          = 16,
  parameter int LOG_EXP_ITERATIONS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             en_i,
  input  wire logic [G_W-1:0]                   g_i,
  input  wire rplfv_pkg::pow_side_t             side_i,
  input  wire logic [rplfv_pkg::DATA_W-1:0]     mu0_i,
  input  wire logic [rplfv_pkg::FLOW_W-1:0]     flow_i,
  output logic [rplfv_pkg::T_W-1:0]             t2_o,
  output rplfv_pkg::pow_side_t                  side_o
);
  localparam int L      = LOG_EXP_ITERATIONS;
  localparam int POS_W  = $clog2(G_W);
  localparam int LI_W   = POS_W + 1;
  localparam int LOG_W  = LI_W + 32;
  localparam int E_W    = rplfv_pkg::FLOW_W + 1;
  localparam int P_W    = E_W + LOG_W;
  localparam int Y_W    = P_W - rplfv_pkg::N_FRAC;
  localparam int IP_W   = Y_W - 32;
  localparam int S_W    = IP_W + 1;
  localparam int T_W    = rplfv_pkg::T_W;
  localparam int X_W    = 31;
  localparam int ACC_W  = 32;
  localparam logic [T_W-1:0] SAT = rplfv_pkg::TERM_SAT;

  // leading one of g
  logic [POS_W-1:0]     pos_d, pos_q;
  logic [G_W-1:0]       ga_q;
  rplfv_pkg::pow_side_t sa_q, sb_q, sm_q, sv_q;

  always_comb begin
    pos_d = '0;
    for (int j = 0; j < G_W; j++) begin
      if (g_i[j]) pos_d = POS_W'(j);
    end
  end

  logic [G_W+29:0]         norm;
  logic [X_W-1:0]          xb_q;
  logic signed [LI_W-1:0]  lib_q;

  assign norm = {ga_q, 30'b0} >> pos_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_q <= pos_d;
      ga_q  <= g_i;
      sa_q  <= side_i;
      xb_q  <= norm[X_W-1:0];
      lib_q <= $signed({1'b0, pos_q}) - $signed(LI_W'(FRAC_BITS));
      sb_q  <= sa_q;
    end
  end

  // one fraction bit of log2 per squaring
  logic [X_W-1:0]          x_q    [L];
  logic [31:0]             fr_q   [L];
  logic signed [LI_W-1:0]  li_q   [L];
  rplfv_pkg::pow_side_t    sl_q   [L];

  for (genvar i = 0; i < L; i++) begin : g_log
    logic [X_W-1:0]         x_in;
    logic [31:0]            fr_in;
    logic signed [LI_W-1:0] li_in;
    rplfv_pkg::pow_side_t   s_in;
    logic [61:0]            sq;
    logic [31:0]            t;
    if (i == 0) begin : g_first
      assign x_in  = xb_q;
      assign fr_in = '0;
      assign li_in = lib_q;
      assign s_in  = sb_q;
    end else begin : g_next
      assign x_in  = x_q[i-1];
      assign fr_in = fr_q[i-1];
      assign li_in = li_q[i-1];
      assign s_in  = sl_q[i-1];
    end
    assign sq = {31'b0, x_in} * {31'b0, x_in};
    assign t  = sq[61:30];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]  <= t[31] ? t[31:1] : t[X_W-1:0];
        fr_q[i] <= fr_in | (t[31] ? (32'd1 << (31 - i)) : 32'd0);
        li_q[i] <= li_in;
        sl_q[i] <= s_in;
      end
    end
  end

  // exponent (n-1)*log2 g, floor to q32
  logic signed [LOG_W-1:0] log_v;
  logic signed [E_W-1:0]   e_v;
  logic signed [P_W-1:0]   prod;
  logic signed [Y_W-1:0]   y_q;

  assign log_v = {li_q[L-1], fr_q[L-1]};
  assign e_v   = $signed({1'b0, flow_i}) - $signed(E_W'(rplfv_pkg::FLOW_ONE));
  assign prod  = P_W'(e_v) * P_W'(log_v);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q  <= Y_W'(prod >>> rplfv_pkg::N_FRAC);
      sm_q <= sl_q[L-1];
    end
  end

  // 2^f as a product of constant roots
  logic [ACC_W-1:0]       acc_q [L];
  logic [31:0]            f_q   [L];
  logic signed [IP_W-1:0] ip_q  [L];
  rplfv_pkg::pow_side_t   se_q  [L];

  for (genvar i = 0; i < L; i++) begin : g_exp
    localparam logic [31:0] ROOT = rplfv_pkg::exp_root(i + 1);
    logic [ACC_W-1:0]       acc_in;
    logic [31:0]            f_in;
    logic signed [IP_W-1:0] ip_in;
    rplfv_pkg::pow_side_t   s_in;
    logic [63:0]            mul;
    if (i == 0) begin : g_first
      assign acc_in = ACC_W'(64'd1 << 30);
      assign f_in   = y_q[31:0];
      assign ip_in  = y_q[Y_W-1:32];
      assign s_in   = sm_q;
    end else begin : g_next
      assign acc_in = acc_q[i-1];
      assign f_in   = f_q[i-1];
      assign ip_in  = ip_q[i-1];
      assign s_in   = se_q[i-1];
    end
    assign mul = 64'(acc_in) * 64'(ROOT);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[i] <= f_in[31-i] ? mul[30 +: ACC_W] : acc_in;
        f_q[i]   <= f_in;
        ip_q[i]  <= ip_in;
        se_q[i]  <= s_in;
      end
    end
  end

  logic [63:0]            v_q;
  logic signed [IP_W-1:0] ipv_q;
  logic signed [S_W-1:0]  sh;
  logic [S_W-1:0]         nsh;
  logic [63:0]            up, dn;
  logic [T_W-1:0]         t2_d, t2_q;
  rplfv_pkg::pow_side_t   so_q;

  // scale by 2^(ip-30), clamp at the term limit
  always_comb begin
    sh   = S_W'(ipv_q) - $signed(S_W'(30));
    nsh  = -sh;
    up   = v_q << sh[5:0];
    dn   = v_q >> nsh[5:0];
    t2_d = '0;
    if (v_q == '0) begin
      t2_d = '0;
    end else if (!sh[S_W-1]) begin
      if (sh >= S_W'(40) || v_q > (64'(SAT) >> sh[5:0])) t2_d = SAT;
      else t2_d = up[T_W-1:0];
    end else if (nsh >= S_W'(64)) begin
      t2_d = '0;
    end else if (dn > 64'(SAT)) begin
      t2_d = SAT;
    end else begin
      t2_d = dn[T_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q   <= 64'(mu0_i) * 64'(acc_q[L-1]);
      ipv_q <= ip_q[L-1];
      sv_q  <= se_q[L-1];
      t2_q  <= t2_d;
      so_q  <= sv_q;
    end
  end

  assign t2_o   = t2_q;
  assign side_o = so_q;
endmodule
`default_nettype wire

[design/regularized_power_law_face_viscosity.sv]
// Regularized Herschel-Bulkley face viscosity: a fully pipelined unit that takes one
// twelve-velocity face stencil per cycle and returns one metric-scaled viscosity per
// stencil, in order. An accepted stencil reaches the output register through the 32-step
// square root, the two one-bit-per-stage dividers (strain over cell size, then yield
// stress over strain) and the squaring log2 and root-product exp2 chains. Throughput
// is one stencil per cycle; the output register decouples the sides and a stalled output
// freezes the pipeline without losing beats. Registers are written over APB at byte
// address 4*index and must only change while the pipeline is empty.
`default_nettype none
module regularized_power_law_face_viscosity #(
  parameter int FRAC_BITS          = 16,
  parameter int LOG_EXP_ITERATIONS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [rplfv_pkg::ADDR_W-1:0]  paddr_i,
  input  wire logic [31:0]                   pwdata_i,
  output logic [31:0]                        prdata_o,
  output logic                               pready_o,
  rplfv_in_if.sink                           in_i,
  rplfv_out_if.source                        out_o
);
  localparam int DATA_W  = rplfv_pkg::DATA_W;
  localparam int FLOW_W  = rplfv_pkg::FLOW_W;
  localparam int T_W     = rplfv_pkg::T_W;
  localparam int G_W     = 35 + FRAC_BITS;
  localparam int N2_W    = 31 + FRAC_BITS;
  localparam int POW_LAT = 2 * LOG_EXP_ITERATIONS + 5;
  localparam int LAT     = rplfv_pkg::STR_LAT + G_W + N2_W + POW_LAT + 2;
  localparam int Q2X_W   = (N2_W > T_W) ? N2_W : T_W;
  localparam logic [T_W-1:0] SAT = rplfv_pkg::TERM_SAT;

  // configuration registers
  logic [DATA_W-1:0] yield_q, base_q, cap_q, cell_q, face_q;
  logic [FLOW_W-1:0] flow_q;
  logic              wr_en;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yield_q <= '0;
      base_q  <= DATA_W'(32'd65536);
      flow_q  <= rplfv_pkg::FLOW_ONE;
      cap_q   <= DATA_W'(32'd65536000);
      cell_q  <= DATA_W'(32'd1024);
      face_q  <= DATA_W'(32'd65536);
    end else if (wr_en) begin
      unique case (rplfv_pkg::reg_idx_e'(paddr_i[4:2]))
        rplfv_pkg::REG_YIELD: yield_q <= pwdata_i;
        rplfv_pkg::REG_BASE:  base_q  <= pwdata_i;
        rplfv_pkg::REG_FLOW:  flow_q  <= pwdata_i[FLOW_W-1:0];
        rplfv_pkg::REG_CAP:   cap_q   <= pwdata_i;
        rplfv_pkg::REG_CELL:  cell_q  <= pwdata_i;
        rplfv_pkg::REG_FACE:  face_q  <= pwdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (rplfv_pkg::reg_idx_e'(paddr_i[4:2]))
      rplfv_pkg::REG_YIELD: prdata_o = yield_q;
      rplfv_pkg::REG_BASE:  prdata_o = base_q;
      rplfv_pkg::REG_FLOW:  prdata_o = 32'(flow_q);
      rplfv_pkg::REG_CAP:   prdata_o = cap_q;
      rplfv_pkg::REG_CELL:  prdata_o = cell_q;
      rplfv_pkg::REG_FACE:  prdata_o = face_q;
      default:              prdata_o = '0;
    endcase
  end

  // pipeline advance: frozen only when the output beat waits and the last stage is full
  logic           adv;
  logic [LAT-1:0] vld_q;
  logic           out_valid_q;

  assign adv        = !out_valid_q || out_o.ready || !vld_q[LAT-1];
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  rplfv_pkg::stencil_t stencil;
  assign stencil = '{
    ux_here: in_i.ux_here, ux_left: in_i.ux_left, ux_up: in_i.ux_up,
    ux_down: in_i.ux_down, ux_left_up: in_i.ux_left_up, ux_left_down: in_i.ux_left_down,
    uy_here: in_i.uy_here, uy_left: in_i.uy_left, uy_up: in_i.uy_up,
    uy_down: in_i.uy_down, uy_left_up: in_i.uy_left_up, uy_left_down: in_i.uy_left_down
  };

  logic [rplfv_pkg::ROOT_W-1:0] m;
  rplfv_pkg::strain_flags_t     flags;

  rplfv_strain u_strain (
    .clk_i     (clk_i),
    .en_i      (adv),
    .stencil_i (stencil),
    .m_o       (m),
    .flags_o   (flags)
  );

  // g = (m << k) << (FRAC_BITS-3) / cell_size
  logic [G_W-1:0]    num1, q1;
  logic [DATA_W-1:0] cell_div;
  logic              zero1;

  assign num1     = (G_W'(m) << flags.k) << (FRAC_BITS - 3);
  assign cell_div = (cell_q == '0) ? DATA_W'(1) : cell_q;

  rplfv_div #(.N_W(G_W), .D_W(DATA_W), .S_W(1)) u_div_g (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (num1),
    .den_i  (cell_div),
    .side_i (flags.zero),
    .quo_o  (q1),
    .side_o (zero1)
  );

  // yield term: (yield_stress << (FRAC_BITS-1)) / g
  logic [G_W-1:0]   g;
  logic [N2_W-1:0]  num2, q2;
  logic [G_W:0]     side2;
  logic [Q2X_W-1:0] q2x;
  rplfv_pkg::pow_side_t pside_in, pside_out;
  logic [T_W-1:0]   t2;

  assign g    = (q1 == '0) ? G_W'(1) : q1;
  assign num2 = N2_W'(yield_q) << (FRAC_BITS - 1);

  rplfv_div #(.N_W(N2_W), .D_W(G_W), .S_W(G_W + 1)) u_div_t1 (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (num2),
    .den_i  (g),
    .side_i ({zero1, g}),
    .quo_o  (q2),
    .side_o (side2)
  );

  assign q2x           = Q2X_W'(q2);
  assign pside_in.zero = side2[G_W];
  assign pside_in.t1   = (q2x > Q2X_W'(SAT)) ? SAT : q2x[T_W-1:0];

  rplfv_pow #(
    .G_W                (G_W),
    .FRAC_BITS          (FRAC_BITS),
    .LOG_EXP_ITERATIONS (LOG_EXP_ITERATIONS)
  ) u_pow (
    .clk_i  (clk_i),
    .en_i   (adv),
    .g_i    (side2[G_W-1:0]),
    .side_i (pside_in),
    .mu0_i  (base_q),
    .flow_i (flow_q),
    .t2_o   (t2),
    .side_o (pside_out)
  );

  // sum, cap and the zero-strain cases
  logic [T_W:0]      sum;
  logic [DATA_W-1:0] mu_d, mu_q;
  logic              capd, cap1_q, cap2_q;
  logic [63:0]       prod_q, prod_sh;

  always_comb begin
    sum = (T_W + 1)'(pside_out.t1) + (T_W + 1)'(t2);
    if (sum > (T_W + 1)'(SAT)) sum = (T_W + 1)'(SAT);
    mu_d = '0;
    capd = 1'b0;
    if (!pside_out.zero) begin
      if (sum >= (T_W + 1)'(cap_q)) begin
        mu_d = cap_q;
        capd = 1'b1;
      end else begin
        mu_d = sum[DATA_W-1:0];
      end
    end else if (yield_q != '0 || flow_q < rplfv_pkg::FLOW_ONE) begin
      mu_d = cap_q;
      capd = 1'b1;
    end else if (flow_q == rplfv_pkg::FLOW_ONE) begin
      mu_d = base_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mu_q   <= mu_d;
      cap1_q <= capd;
      prod_q <= 64'(face_q) * 64'(mu_q);
      cap2_q <= cap1_q;
    end
  end

  assign prod_sh = prod_q >> FRAC_BITS;

  logic [DATA_W-1:0] fv_q;
  logic              at_cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= vld_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if ((!out_valid_q || out_o.ready) && vld_q[LAT-1]) begin
      fv_q     <= (prod_sh[63:32] != '0) ? '1 : prod_sh[31:0];
      at_cap_q <= cap2_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.face_viscosity = fv_q;
  assign out_o.at_cap         = at_cap_q;
endmodule
`default_nettype wire

[design/rplfv_checker.sv]
// port-level checks for the face viscosity block, bound to the top level
`default_nettype none
module rplfv_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         psel_i,
  input wire logic                         penable_i,
  input wire logic                         pwrite_i,
  input wire logic [rplfv_pkg::ADDR_W-1:0] paddr_i,
  input wire logic [31:0]                  pwdata_i,
  input wire logic [31:0]                  prdata_i,
  input wire logic                         in_ready_i,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic [31:0]                  face_viscosity_i,
  input wire logic                         at_cap_i
);
  // an empty output slot always lets a stencil in
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(face_viscosity_i) && $stable(at_cap_i)))
    else $error("output beat changed while stalled");

  // a 32-bit register reads back what was just written to it
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(psel_i && penable_i && pwrite_i) && psel_i && !pwrite_i
     && paddr_i == $past(paddr_i) && paddr_i[4:2] != rplfv_pkg::REG_FLOW
     && paddr_i[4:2] <= rplfv_pkg::REG_FACE) |-> prdata_i == $past(pwdata_i))
    else $error("register readback mismatch");
endmodule

bind regularized_power_law_face_viscosity rplfv_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .psel_i           (psel_i),
  .penable_i        (penable_i),
  .pwrite_i         (pwrite_i),
  .paddr_i          (paddr_i),
  .pwdata_i         (pwdata_i),
  .prdata_i         (prdata_o),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .face_viscosity_i (out_o.face_viscosity),
  .at_cap_i         (out_o.at_cap)
);
`default_nettype wire
